// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile all of them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/ipe_pkg.sv =====
package ipe_pkg;

    // Colour table geometry
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_PIXEL_SIZE   = 2'd0;
    localparam logic [1:0] CFG_ROW_BYTES    = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_PALETTE_LAST = 2'd3;

    // Register reset values
    localparam logic [1:0]  RST_PIXEL_SIZE   = 2'd3;
    localparam logic [13:0] RST_ROW_BYTES    = 14'd4;
    localparam logic [15:0] RST_IMAGE_WIDTH  = 16'd32;
    localparam logic [7:0]  RST_PALETTE_LAST = 8'd1;

    // Input word kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // One colour table entry as stored
    typedef struct packed {
        logic [15:0] value;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pal_entry_t;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PIXEL = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;         // write a table entry, restart the row
        logic start_byte;   // latch a data byte, advance the row position
        logic start_pixel;  // begin a table search for the current pixel
        logic scan;         // one search step
        logic push;         // move the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic pad;       // current column lies beyond the image width
        logic hit;       // entry under compare matches the pixel
        logic at_limit;  // entry under compare is the last one searched
        logic out_free;  // output register can take a word this cycle
        logic last;      // current pixel is the final visible one of the byte
    } dp_sts_t;

endpackage

// ===== rtl/ipe_ram.sv =====
module ipe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ipe_datapath.sv =====
`include "assert_macros.svh"

module ipe_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  ipe_pkg::dp_cmd_t cmd,
    output ipe_pkg::dp_sts_t sts,
    input  logic [7:0]       data_byte,
    input  logic [7:0]       entry_index,
    input  logic [15:0]      entry_value,
    input  logic [15:0]      entry_red,
    input  logic [15:0]      entry_green,
    input  logic [15:0]      entry_blue,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [15:0]      red,
    output logic [15:0]      green,
    output logic [15:0]      blue,
    output logic             found,
    output logic             last_pixel
);

    // Configuration
    logic [1:0]  size_code_reg, size_code_next;
    logic [13:0] row_bytes_reg, row_bytes_next;
    logic [15:0] width_reg,     width_next;
    logic [7:0]  pal_last_reg,  pal_last_next;

    // Row and pixel tracking
    logic [13:0] row_pos_reg, row_pos_next;
    logic [13:0] row_pos_inc;
    logic [7:0]  px_reg, px_next;
    logic [2:0]  k_reg, k_next;
    logic [16:0] col_reg, col_next;
    logic [1:0]  col_shift;

    // Search
    logic [ipe_pkg::PAL_AW-1:0] cmp_addr_reg, cmp_addr_next;
    logic [ipe_pkg::PAL_AW-1:0] rd_addr;
    logic [ipe_pkg::PAL_AW-1:0] limit;
    logic [63:0]                rd_word;
    ipe_pkg::pal_entry_t        rd_entry;
    ipe_pkg::pal_entry_t        wr_entry;
    logic                       wr_en;
    logic [7:0]                 pix;
    logic [2:0]                 kmax;

    // Search result
    logic [15:0] res_red_reg,   res_red_next;
    logic [15:0] res_green_reg, res_green_next;
    logic [15:0] res_blue_reg,  res_blue_next;
    logic        res_found_reg, res_found_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_red_reg,   out_red_next;
    logic [15:0] out_green_reg, out_green_next;
    logic [15:0] out_blue_reg,  out_blue_next;
    logic        out_found_reg, out_found_next;
    logic        out_last_reg,  out_last_next;
    logic        out_free;

    // Colour table
    assign wr_en    = cmd.load && (int'(entry_index) < ipe_pkg::PAL_DEPTH);
    assign wr_entry = '{value: entry_value, red: entry_red,
                        green: entry_green, blue: entry_blue};
    assign rd_addr  = cmd.start_pixel ? '0 : ipe_pkg::PAL_AW'(cmp_addr_reg + 1'b1);
    assign rd_entry = rd_word;

    ipe_ram #(
        .WIDTH (64),
        .DEPTH (ipe_pkg::PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (wr_en),
        .waddr (entry_index[ipe_pkg::PAL_AW-1:0]),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    // Search bound, clipped to the table
    assign limit = (int'(pal_last_reg) > ipe_pkg::PAL_DEPTH - 1)
                 ? ipe_pkg::PAL_AW'(ipe_pkg::PAL_DEPTH - 1)
                 : pal_last_reg[ipe_pkg::PAL_AW-1:0];

    // Current pixel: top bits of the shifted byte
    always_comb
    begin
        case (size_code_reg)
            2'd0:    pix = {7'd0, px_reg[7]};
            2'd1:    pix = {6'd0, px_reg[7:6]};
            2'd2:    pix = {4'd0, px_reg[7:4]};
            default: pix = px_reg;
        endcase
    end

    // Last pixel slot of a byte
    always_comb
    begin
        case (size_code_reg)
            2'd0:    kmax = 3'd7;
            2'd1:    kmax = 3'd3;
            2'd2:    kmax = 3'd1;
            default: kmax = 3'd0;
        endcase
    end

    assign col_shift = 2'd3 - size_code_reg;
    assign row_pos_inc = row_pos_reg + 14'd1;
    assign out_free = !out_valid_reg || !out_stall;

    // Status
    assign sts.pad      = col_reg >= {1'b0, width_reg};
    assign sts.hit      = rd_entry.value == {8'd0, pix};
    assign sts.at_limit = cmp_addr_reg == limit;
    assign sts.out_free = out_free;
    assign sts.last     = (k_reg == kmax) || (col_reg + 17'd1 == {1'b0, width_reg});

    // Configuration writes
    always_comb
    begin
        size_code_next = size_code_reg;
        row_bytes_next = row_bytes_reg;
        width_next     = width_reg;
        pal_last_next  = pal_last_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ipe_pkg::CFG_PIXEL_SIZE:   size_code_next = cfg_data[1:0];
                ipe_pkg::CFG_ROW_BYTES:    row_bytes_next = cfg_data[13:0];
                ipe_pkg::CFG_IMAGE_WIDTH:  width_next     = cfg_data;
                ipe_pkg::CFG_PALETTE_LAST: pal_last_next  = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Row position and pixel walk
    always_comb
    begin
        row_pos_next = row_pos_reg;
        px_next      = px_reg;
        k_next       = k_reg;
        col_next     = col_reg;
        if (cmd.load)
        begin
            row_pos_next = '0;
        end
        else if (cmd.start_byte)
        begin
            row_pos_next = (row_pos_inc >= row_bytes_reg) ? '0 : row_pos_inc;
            px_next      = data_byte;
            k_next       = '0;
            col_next     = 17'({3'd0, row_pos_reg} << col_shift);
        end
        else if (cmd.push)
        begin
            k_next   = k_reg + 3'd1;
            col_next = col_reg + 17'd1;
            case (size_code_reg)
                2'd0:    px_next = {px_reg[6:0], 1'b0};
                2'd1:    px_next = {px_reg[5:0], 2'b0};
                2'd2:    px_next = {px_reg[3:0], 4'b0};
                default: px_next = '0;
            endcase
        end
    end

    // Table search, one entry a cycle
    always_comb
    begin
        cmp_addr_next  = cmp_addr_reg;
        res_red_next   = res_red_reg;
        res_green_next = res_green_reg;
        res_blue_next  = res_blue_reg;
        res_found_next = res_found_reg;
        if (cmd.start_pixel)
        begin
            cmp_addr_next = '0;
        end
        else if (cmd.scan)
        begin
            cmp_addr_next = ipe_pkg::PAL_AW'(cmp_addr_reg + 1'b1);
            if (sts.hit)
            begin
                res_red_next   = rd_entry.red;
                res_green_next = rd_entry.green;
                res_blue_next  = rd_entry.blue;
                res_found_next = 1'b1;
            end
            else if (sts.at_limit)
            begin
                res_red_next   = '0;
                res_green_next = '0;
                res_blue_next  = '0;
                res_found_next = 1'b0;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_red_next   = res_red_reg;
            out_green_next = res_green_reg;
            out_blue_next  = res_blue_reg;
            out_found_next = res_found_reg;
            out_last_next  = sts.last;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_code_reg <= ipe_pkg::RST_PIXEL_SIZE;
            row_bytes_reg <= ipe_pkg::RST_ROW_BYTES;
            width_reg     <= ipe_pkg::RST_IMAGE_WIDTH;
            pal_last_reg  <= ipe_pkg::RST_PALETTE_LAST;
            row_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_code_reg <= size_code_next;
            row_bytes_reg <= row_bytes_next;
            width_reg     <= width_next;
            pal_last_reg  <= pal_last_next;
            row_pos_reg   <= row_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        k_reg         <= k_next;
        col_reg       <= col_next;
        cmp_addr_reg  <= cmp_addr_next;
        res_red_reg   <= res_red_next;
        res_green_reg <= res_green_next;
        res_blue_reg  <= res_blue_next;
        res_found_reg <= res_found_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign red        = out_red_reg;
    assign green      = out_green_reg;
    assign blue       = out_blue_reg;
    assign found      = out_found_reg;
    assign last_pixel = out_last_reg;

    // Checks
    `ASSERT_PROP(a_scan_in_bound, clk, rst_n, cmd.scan |-> cmp_addr_reg <= limit)
    `ASSERT_NEVER(a_push_over_word, clk, rst_n, cmd.push && out_valid_reg && out_stall)
    `ASSERT_PROP(a_slot_in_byte, clk, rst_n, cmd.push |-> k_reg <= kmax)

endmodule

// ===== rtl/ipe_ctrl.sv =====
`include "assert_macros.svh"

module ipe_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             action,
    output ipe_pkg::dp_cmd_t cmd,
    input  ipe_pkg::dp_sts_t sts
);

    ipe_pkg::state_t state_reg, state_next;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ipe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ipe_pkg::ACT_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start_byte = 1'b1;
                        state_next     = ipe_pkg::ST_PIXEL;
                    end
                end
            end
            ipe_pkg::ST_PIXEL:
            begin
                if (sts.pad)
                begin
                    state_next = ipe_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.start_pixel = 1'b1;
                    state_next      = ipe_pkg::ST_SCAN;
                end
            end
            ipe_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.at_limit)
                begin
                    state_next = ipe_pkg::ST_PUSH;
                end
            end
            ipe_pkg::ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = sts.last ? ipe_pkg::ST_IDLE : ipe_pkg::ST_PIXEL;
                end
            end
            default:
            begin
                state_next = ipe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input taken only between bytes
    assign in_stall = state_reg != ipe_pkg::ST_IDLE;

    // Checks
    `ASSERT_PROP(a_scan_ends_in_push, clk, rst_n, (state_reg == ipe_pkg::ST_SCAN) && (sts.hit || sts.at_limit) |=> state_reg == ipe_pkg::ST_PUSH)
    `ASSERT_PROP(a_byte_starts_walk, clk, rst_n, in_valid && !in_stall && (action == ipe_pkg::ACT_PIXEL) |=> state_reg == ipe_pkg::ST_PIXEL)
    `ASSERT_PROP(a_load_stays_idle, clk, rst_n, in_valid && !in_stall && (action == ipe_pkg::ACT_LOAD) |=> !in_stall)

endmodule

// ===== rtl/indexed_pixel_palette_expand.sv =====
// Channel   Handshake              Word
// --------  ---------------------  --------------------------------------------
// in        in_valid / in_stall    action, data_byte, entry_index, entry_value,
//                                  entry_red, entry_green, entry_blue
// out       out_valid / out_stall  red, green, blue, found, last_pixel
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load word leaves the sequencer idle. A data byte is accepted, then each
// visible pixel takes a set-up step, a compare step per table slot up to the
// one that matched (or the search bound) on the single table read port, and a
// step into the output register. A padding byte ends after the set-up step. The
// table is not cleared at reset; the row position, configuration and output
// valid registers are. out_stall holds the sequencer in its output step only.

module indexed_pixel_palette_expand (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  entry_index,
    input  logic [15:0] entry_value,
    input  logic [15:0] entry_red,
    input  logic [15:0] entry_green,
    input  logic [15:0] entry_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue,
    output logic        found,
    output logic        last_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ipe_pkg::dp_cmd_t cmd;
    ipe_pkg::dp_sts_t sts;

    // Registers always accept a write
    assign cfg_ready = 1'b1;

    ipe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .cmd      (cmd),
        .sts      (sts)
    );

    ipe_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .data_byte   (data_byte),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .found       (found),
        .last_pixel  (last_pixel)
    );

endmodule
